@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/ctpc_pkg.sv @@
`timescale 1ns / 1ps
package ctpc_pkg;

    localparam int RAW_SAMPLE_W = 22;
    localparam int TIME_W       = 48;
    localparam int EVENT_W      = 2;
    localparam int PHASE_W      = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;
    localparam int PCT_W        = 7;
    localparam int DEB_W        = 4;
    localparam int DUR_W        = 24;

    localparam logic [PHASE_W-1:0] PH_CAL  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_RUN  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_FAIL = 2'd2;

    localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
    localparam logic [EVENT_W-1:0] EV_SHORT = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LONG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN       = 2'd3;

    localparam logic [PCT_W-1:0] PCT_RESET  = 7'd75;
    localparam logic [DEB_W-1:0] DEB_RESET  = 4'd3;
    localparam logic [DUR_W-1:0] LONG_RESET = 24'd1200000;
    localparam logic [DUR_W-1:0] MIN_RESET  = 24'd60000;

    // percent scale and baseline filter shift (31/32 average)
    localparam int PCT_SCALE = 100;
    localparam int BASE_SH   = 5;

    typedef struct packed {
        logic load;
        logic cal_step;
        logic fail;
        logic div_start;
        logic div_step;
        logic div_finish;
        logic mul;
        logic upd;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               read_ok;
        logic               cal_done;
        logic               vc_zero;
        logic               div_last;
    } t_dp_sts;

endpackage

@@ rtl/ctpc_ifs.sv @@
`timescale 1ns / 1ps
interface ctpc_sample_if import ctpc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [RAW_SAMPLE_W-1:0] raw_sample;
    logic                    read_ok;
    logic [TIME_W-1:0]       time_us;

    modport source(output valid, raw_sample, read_ok, time_us, input ready);
    modport sink(input valid, raw_sample, read_ok, time_us, output ready);
endinterface

interface ctpc_result_if import ctpc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [EVENT_W-1:0]      press_event;
    logic [PHASE_W-1:0]      phase;
    logic                    is_touched;
    logic [RAW_SAMPLE_W-1:0] baseline_level;

    modport source(output valid, press_event, phase, is_touched, baseline_level, input ready);
    modport sink(input valid, press_event, phase, is_touched, baseline_level, output ready);
endinterface

interface ctpc_cfg_if import ctpc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/ctpc_div.sv @@
`timescale 1ns / 1ps
module ctpc_div #(
    parameter int DIVIDEND_W = 28,
    parameter int DIVISOR_W  = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_step,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic [DIVIDEND_W-1:0] o_quotient,
    output logic                  o_last
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_den;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    // restoring divide, one quotient bit per step
    always_comb begin
        rem_sh = {r_rem, r_quo[DIVIDEND_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (i_step) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
            r_rem <= ge ? diff[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= '0;
        end else if (i_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_quotient = r_quo;
    assign o_last     = r_cnt == CNT_W'(DIVIDEND_W - 1);

endmodule

@@ rtl/ctpc_dp.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ctpc_dp import ctpc_pkg::*; #(
    parameter int CAL_SAMPLES = 32,
    parameter int SAMPLE_BITS = 22
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_sts                 o_sts,
    input  logic [RAW_SAMPLE_W-1:0] i_raw_sample,
    input  logic                    i_read_ok,
    input  logic [TIME_W-1:0]       i_time_us,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output logic [EVENT_W-1:0]      o_press_event,
    output logic [PHASE_W-1:0]      o_phase,
    output logic                    o_is_touched,
    output logic [RAW_SAMPLE_W-1:0] o_baseline_level
);

    localparam int RAW_W  = (SAMPLE_BITS < RAW_SAMPLE_W) ? SAMPLE_BITS : RAW_SAMPLE_W;
    localparam int CNT_W  = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W  = RAW_W + CNT_W;
    localparam int PROD_W = RAW_W + PCT_W;
    localparam int FILT_W = RAW_W + BASE_SH;

    // configuration
    logic [PCT_W-1:0] r_pct;
    logic [DEB_W-1:0] r_deb;
    logic [DUR_W-1:0] r_long;
    logic [DUR_W-1:0] r_min;

    // latched input word
    logic [RAW_W-1:0]  r_raw;
    logic              r_ok;
    logic [TIME_W-1:0] r_time;

    // block state
    logic [PHASE_W-1:0] r_phase;
    logic [CNT_W-1:0]   r_slot;
    logic [CNT_W-1:0]   r_vc;
    logic [SUM_W-1:0]   r_sum;
    logic [RAW_W-1:0]   r_base;
    logic               r_stable;
    logic               r_cand;
    logic [DEB_W-1:0]   r_match;
    logic [TIME_W-1:0]  r_press;
    logic [EVENT_W-1:0] r_ev;
    logic [PROD_W-1:0]  r_prod;

    // output word
    logic [EVENT_W-1:0]      r_o_ev;
    logic [PHASE_W-1:0]      r_o_phase;
    logic                    r_o_touch;
    logic [RAW_SAMPLE_W-1:0] r_o_base;

    logic [SUM_W-1:0]   quotient;
    logic               div_last;
    logic [PROD_W-1:0]  lim;
    logic               touched;
    logic               n_cand;
    logic [DEB_W-1:0]   n_match;
    logic               n_stable;
    logic               n_press_set;
    logic [EVENT_W-1:0] n_ev;
    logic [TIME_W-1:0]  dur;
    logic [FILT_W-1:0]  filt;
    logic               base_track;
    logic               live;

    ctpc_div #(
        .DIVIDEND_W(SUM_W),
        .DIVISOR_W (CNT_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_step    (i_cmd.div_step),
        .i_dividend(r_sum),
        .i_divisor (r_vc),
        .o_quotient(quotient),
        .o_last    (div_last)
    );

    // touched when raw < floor(base*pct/100), i.e. base*pct >= 100*(raw+1)
    always_comb begin
        lim         = PROD_W'(r_raw) * PROD_W'(PCT_SCALE) + PROD_W'(PCT_SCALE);
        touched     = r_prod >= lim;
        n_cand      = r_cand;
        n_match     = r_match;
        n_stable    = r_stable;
        n_press_set = 1'b0;
        n_ev        = EV_NONE;
        dur         = r_time - r_press;
        if (touched == r_cand) begin
            if (r_match < r_deb) begin
                n_match = r_match + 1'b1;
            end
        end else begin
            n_cand  = touched;
            n_match = DEB_W'(1);
        end
        if (n_match >= r_deb && r_stable != n_cand) begin
            n_stable = n_cand;
            if (n_cand) begin
                n_press_set = 1'b1;
            end else if (dur >= TIME_W'(r_long)) begin
                n_ev = EV_LONG;
            end else if (dur >= TIME_W'(r_min)) begin
                n_ev = EV_SHORT;
            end
        end
        base_track = !n_stable && !n_cand;
        filt       = (FILT_W'(r_base) << BASE_SH) - FILT_W'(r_base) + FILT_W'(r_raw);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct  <= PCT_RESET;
            r_deb  <= DEB_RESET;
            r_long <= LONG_RESET;
            r_min  <= MIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_pct  <= i_cfg_data[PCT_W-1:0];
                CFG_DEBOUNCE:  r_deb  <= i_cfg_data[DEB_W-1:0];
                CFG_LONG:      r_long <= i_cfg_data[DUR_W-1:0];
                CFG_MIN:       r_min  <= i_cfg_data[DUR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw  <= i_raw_sample[RAW_W-1:0];
            r_ok   <= i_read_ok;
            r_time <= i_time_us;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_base) * PROD_W'(r_pct);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_CAL;
            r_slot   <= '0;
            r_vc     <= '0;
            r_sum    <= '0;
            r_base   <= '0;
            r_stable <= 1'b0;
            r_cand   <= 1'b0;
            r_match  <= '0;
            r_press  <= '0;
            r_ev     <= EV_NONE;
        end else begin
            if (i_cmd.load) begin
                r_ev <= EV_NONE;
            end
            if (i_cmd.cal_step) begin
                r_slot <= r_slot + 1'b1;
                if (r_ok) begin
                    r_sum <= r_sum + SUM_W'(r_raw);
                    r_vc  <= r_vc + 1'b1;
                end
            end
            if (i_cmd.fail) begin
                r_phase <= PH_FAIL;
            end
            if (i_cmd.div_finish) begin
                r_base  <= quotient[RAW_W-1:0];
                r_phase <= PH_RUN;
            end
            if (i_cmd.upd) begin
                r_cand   <= n_cand;
                r_match  <= n_match;
                r_stable <= n_stable;
                r_ev     <= n_ev;
                if (n_press_set) begin
                    r_press <= r_time;
                end
                if (base_track) begin
                    r_base <= filt[FILT_W-1:BASE_SH];
                end
            end
        end
    end

    assign live = r_phase == PH_RUN;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_ev    <= r_ev;
            r_o_phase <= r_phase;
            r_o_touch <= live && r_stable;
            r_o_base  <= live ? RAW_SAMPLE_W'(r_base) : '0;
        end
    end

    assign o_sts.phase    = r_phase;
    assign o_sts.read_ok  = r_ok;
    assign o_sts.cal_done = r_slot >= CNT_W'(CAL_SAMPLES);
    assign o_sts.vc_zero  = r_vc == '0;
    assign o_sts.div_last = div_last;

    assign o_press_event    = r_o_ev;
    assign o_phase          = r_o_phase;
    assign o_is_touched     = r_o_touch;
    assign o_baseline_level = r_o_base;

    `ASSERT_IMPL(a_event_on_release, i_clk, i_rst_n, r_ev != EV_NONE, !r_stable && r_phase == PH_RUN)

endmodule

@@ rtl/ctpc_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ctpc_ctrl import ctpc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CAL  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_UPD  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_sts.phase == PH_CAL) ? S_CAL : S_MUL;
                end
            end
            S_CAL: begin
                o_cmd.cal_step = 1'b1;
                n_state        = S_CHK;
            end
            S_CHK: begin
                if (!i_sts.cal_done) begin
                    n_state = S_DONE;
                end else if (i_sts.vc_zero) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.div_finish = 1'b1;
                n_state          = S_DONE;
            end
            S_MUL: begin
                if (i_sts.phase == PH_RUN && i_sts.read_ok) begin
                    o_cmd.mul = 1'b1;
                    n_state   = S_UPD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `ASSERT_IMPL(a_div_only_calibrating, i_clk, i_rst_n, r_state == S_DIV, i_sts.phase == PH_CAL)
    `ASSERT_NEXT(a_fail_sets_phase, i_clk, i_rst_n, o_cmd.fail, i_sts.phase == PH_FAIL)
    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state != S_IDLE)

endmodule

@@ rtl/capacitive_touch_press_classifier.sv @@
// path: running IDLE, MUL, UPD, DONE (ignored: no UPD); calibration IDLE, CAL, CHK, DONE
// last calibration slot: CHK starts a divide, DIV steps it and FIN loads the baseline,
//     restoring divide at one quotient bit per cycle
// handshake: one word at a time; next word accepted the cycle after the result registers,
//     and DONE holds while a result waits for the sink
// reset: synchronous active low; clears FSM and tracking state, restores config defaults
`timescale 1ns / 1ps
module capacitive_touch_press_classifier import ctpc_pkg::*; #(
    parameter int CAL_SAMPLES = 32,
    parameter int SAMPLE_BITS = 22
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ctpc_sample_if.sink     i_sample,
    ctpc_result_if.source   o_result,
    ctpc_cfg_if.sink        i_cfg
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    ctpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .o_in_ready (i_sample.ready),
        .o_out_valid(o_result.valid),
        .i_out_ready(o_result.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    ctpc_dp #(
        .CAL_SAMPLES(CAL_SAMPLES),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_raw_sample    (i_sample.raw_sample),
        .i_read_ok       (i_sample.read_ok),
        .i_time_us       (i_sample.time_us),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_idx       (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_press_event   (o_result.press_event),
        .o_phase         (o_result.phase),
        .o_is_touched    (o_result.is_touched),
        .o_baseline_level(o_result.baseline_level)
    );

endmodule
